// File: hw/rtl/avcc_to_annexb_converter_core_assert.svh
// Assertion macros for the checker file.
`ifndef AVCC_TO_ANNEXB_CONVERTER_CORE_ASSERT_SVH
`define AVCC_TO_ANNEXB_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AVCC_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AVCC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hw/rtl/avcc_pkg.sv
`timescale 1ns / 1ps

package avcc_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_COUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam logic [2:0]  HEADER_SKIP = 3'd5;
  localparam logic [4:0]  REC_CAP     = 5'd16;
  localparam int          COUNT_W     = 25;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [2:0]  START_LEN   = 3'd4;
  localparam int          TDATA_W     = 40;

  // One accepted request's worth of results.
  typedef struct packed {
    logic [2:0]         n_bytes;
    logic               start_code;
    logic [7:0]         payload;
    logic               has_status;
    status_t            status;
    logic [2:0]         length_size;
    logic [COUNT_W-1:0] count_base;
  } burst_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

// File: hw/rtl/avcc_parse.sv
`timescale 1ns / 1ps

module avcc_parse #(
  parameter int MIN_RECORD_BYTES = 7
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_accept,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output avcc_pkg::burst_t burst
);
  import avcc_pkg::*;

  phase_t               phase_r, phase_nxt, phase_step;
  logic [2:0]           hdr_idx_r, hdr_idx_nxt, hdr_idx_step;
  logic [7:0]           sets_left_r, sets_left_nxt, sets_left_step;
  logic                 second_r, second_nxt, second_step;
  logic [7:0]           len_hi_r, len_hi_nxt, len_hi_step;
  logic [15:0]          pay_left_r, pay_left_nxt, pay_left_step;
  logic [2:0]           lsize_r, lsize_nxt, lsize_step;
  logic [COUNT_W-1:0]   count_r, count_nxt, count_step;
  logic [4:0]           rec_r, rec_nxt, rec_step;
  logic [2:0]           n_bytes;
  logic [COUNT_W:0]     count_sum;
  logic                 entry_done;

  // next state
  always_comb begin
    phase_step     = phase_r;
    hdr_idx_step   = hdr_idx_r;
    sets_left_step = sets_left_r;
    second_step    = second_r;
    len_hi_step    = len_hi_r;
    pay_left_step  = pay_left_r;
    lsize_step     = lsize_r;
    entry_done     = 1'b0;
    rec_step       = (rec_r < REC_CAP) ? rec_r + 5'd1 : rec_r;
    count_sum      = {1'b0, count_r} + (COUNT_W+1)'(n_bytes);
    count_step     = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : count_sum[COUNT_W-1:0];

    unique case (phase_r)
      PH_HEADER: begin
        if (hdr_idx_r == HEADER_SKIP - 3'd1) begin
          lsize_step = {1'b0, in_byte[1:0]} + 3'd1;
        end
        hdr_idx_step = hdr_idx_r + 3'd1;
        if (hdr_idx_step >= HEADER_SKIP) begin
          phase_step = PH_COUNT;
        end
      end
      PH_COUNT: begin
        sets_left_step = second_r ? in_byte : {3'b000, in_byte[4:0]};
        if (sets_left_step != 8'd0) begin
          phase_step = PH_LEN_HI;
        end else if (!second_r) begin
          second_step = 1'b1;
        end else begin
          phase_step = PH_TRAILER;
        end
      end
      PH_LEN_HI: begin
        len_hi_step = in_byte;
        phase_step  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        pay_left_step = {len_hi_r, in_byte};
        if (pay_left_step != 16'd0) begin
          phase_step = PH_PAYLOAD;
        end else begin
          entry_done = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        pay_left_step = pay_left_r - 16'd1;
        entry_done    = (pay_left_step == 16'd0);
      end
      PH_TRAILER: begin
      end
      default: begin
      end
    endcase

    if (entry_done) begin
      sets_left_step = sets_left_r - 8'd1;
      if (sets_left_step != 8'd0) begin
        phase_step = PH_LEN_HI;
      end else if (!second_r) begin
        second_step = 1'b1;
        phase_step  = PH_COUNT;
      end else begin
        phase_step = PH_TRAILER;
      end
    end

    if (in_last) begin
      phase_nxt     = PH_HEADER;
      hdr_idx_nxt   = 3'd0;
      sets_left_nxt = 8'd0;
      second_nxt    = 1'b0;
      len_hi_nxt    = 8'd0;
      pay_left_nxt  = 16'd0;
      lsize_nxt     = 3'd1;
      count_nxt     = '0;
      rec_nxt       = 5'd0;
    end else begin
      phase_nxt     = phase_step;
      hdr_idx_nxt   = hdr_idx_step;
      sets_left_nxt = sets_left_step;
      second_nxt    = second_step;
      len_hi_nxt    = len_hi_step;
      pay_left_nxt  = pay_left_step;
      lsize_nxt     = lsize_step;
      count_nxt     = count_step;
      rec_nxt       = rec_step;
    end
  end

  // outputs
  always_comb begin
    unique case (phase_r)
      PH_LEN_LO:  n_bytes = START_LEN;
      PH_PAYLOAD: n_bytes = 3'd1;
      default:    n_bytes = 3'd0;
    endcase
    burst.n_bytes     = n_bytes;
    burst.start_code  = (phase_r == PH_LEN_LO);
    burst.payload     = in_byte;
    burst.has_status  = in_last;
    burst.length_size = lsize_step;
    burst.count_base  = count_r;
    if (rec_step < 5'(MIN_RECORD_BYTES) || phase_step != PH_TRAILER) begin
      burst.status = ST_TRUNC;
    end else if (count_step == '0) begin
      burst.status = ST_EMPTY;
    end else begin
      burst.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hdr_idx_r   <= 3'd0;
      sets_left_r <= 8'd0;
      second_r    <= 1'b0;
      len_hi_r    <= 8'd0;
      pay_left_r  <= 16'd0;
      lsize_r     <= 3'd1;
      count_r     <= '0;
      rec_r       <= 5'd0;
    end else if (in_accept) begin
      phase_r     <= phase_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      sets_left_r <= sets_left_nxt;
      second_r    <= second_nxt;
      len_hi_r    <= len_hi_nxt;
      pay_left_r  <= pay_left_nxt;
      lsize_r     <= lsize_nxt;
      count_r     <= count_nxt;
      rec_r       <= rec_nxt;
    end
  end

endmodule

// File: hw/rtl/avcc_emit.sv
`timescale 1ns / 1ps

module avcc_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  avcc_pkg::burst_t              burst,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic                          out_tlast,
  output logic                          out_tuser,
  output logic [avcc_pkg::TDATA_W-1:0]  out_tdata
);
  import avcc_pkg::*;

  logic               valid_r, valid_nxt;
  logic [2:0]         idx_r, idx_nxt;
  logic [2:0]         nb_r;
  logic               start_r;
  logic [7:0]         byte_r;
  logic               stat_r;
  status_t            status_r;
  logic [2:0]         lsize_r;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;

  logic               is_byte;
  logic [2:0]         total_items;
  logic               last_item;
  logic [7:0]         o_byte;
  logic [1:0]         o_status;
  logic [COUNT_W-1:0] o_count;
  logic               beat;

  always_comb begin
    is_byte     = (idx_r < nb_r);
    total_items = nb_r + {2'b00, stat_r};
    last_item   = (idx_r == total_items - 3'd1);
    if (!is_byte) begin
      o_byte = 8'h00;
    end else if (start_r) begin
      o_byte = (idx_r == START_LEN - 3'd1) ? 8'h01 : 8'h00;
    end else begin
      o_byte = byte_r;
    end
    o_status = is_byte ? 2'd0 : status_r;
    o_count  = is_byte ? sat_inc(cnt_r) : cnt_r;
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = last_item;
  assign out_tuser  = !is_byte;
  assign out_tdata  = {2'b00, o_count, lsize_r, o_status, o_byte};
  assign beat       = valid_r && out_tready;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      valid_nxt = (burst.n_bytes != 3'd0) || burst.has_status;
      idx_nxt   = 3'd0;
      cnt_nxt   = burst.count_base;
    end else if (beat) begin
      if (last_item) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
      cnt_nxt = o_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 3'd0;
      nb_r    <= 3'd0;
      stat_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
      if (load) begin
        nb_r   <= burst.n_bytes;
        stat_r <= burst.has_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (load) begin
      start_r  <= burst.start_code;
      byte_r   <= burst.payload;
      status_r <= burst.status;
      lsize_r  <= burst.length_size;
    end
  end

endmodule

// File: hw/rtl/avcc_to_annexb_converter_core.sv
`timescale 1ns / 1ps

// Converts an avcC configuration record, streamed one byte per request with
// tlast on its final byte, into Annex B parameter sets: each SPS/PPS comes out
// as 00 00 00 01 followed by its payload. The byte on tlast also yields a
// status item (tuser high): ok, truncated/too short, or no parameter sets,
// with the saturating byte count. Output bytes precede the status, so drop the
// record's output unless status is ok. Throughput is one input byte per cycle
// while the input is not stalled: it stalls on the low length byte of an entry
// while the start code drains from the output sequencer, on the last byte while
// its status item drains, and under downstream backpressure.
module avcc_to_annexb_converter_core #(
  parameter int MIN_RECORD_BYTES = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] out_byte, [9:8] status, [12:10] length_size,
                                  // [37:13] total_bytes, [39:38] zero
  output logic        out_tuser,  // item_kind
  output logic        out_tlast   // end_of_run
);
  import avcc_pkg::*;

  burst_t burst;
  logic   in_accept;

  assign in_tready = !out_tvalid || (out_tready && out_tlast);
  assign in_accept = in_tvalid && in_tready;

  avcc_parse #(
    .MIN_RECORD_BYTES(MIN_RECORD_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .burst     (burst)
  );

  avcc_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_accept),
    .burst      (burst),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

// File: hw/rtl/avcc_chk.sv
`timescale 1ns / 1ps
`include "avcc_to_annexb_converter_core_assert.svh"

module avcc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // stalled result request holds
  `AVCC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable({out_tdata, out_tuser, out_tlast}), "output changed under stall")

  `AVCC_ASSERT_NOW(a_status_ends, out_tvalid && out_tuser, out_tlast, "status item not last of run")

  `AVCC_ASSERT_NOW(a_status_code, out_tvalid && out_tuser, out_tdata[9:8] != 2'd3, "bad status code")

  `AVCC_ASSERT_NOW(a_byte_clean, out_tvalid && !out_tuser, out_tdata[9:8] == 2'd0,
    "status set on byte item")

  `AVCC_ASSERT_NOW(a_lsize, out_tvalid,
    out_tdata[12:10] != 3'd0 && out_tdata[12:10] <= 3'd4, "length size out of range")

endmodule

bind avcc_to_annexb_converter_core avcc_chk u_chk (.*);

// File: bench/tb_avcc_to_annexb_converter_core.sv
`timescale 1ns / 1ps

module tb_avcc_to_annexb_converter_core;
  import avcc_pkg::*;

  localparam int MIN_REC = 7;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  avcc_to_annexb_converter_core #(.MIN_RECORD_BYTES(MIN_REC)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic               kind;
    logic [7:0]         data;
    status_t            st;
    logic [2:0]         lsize;
    logic [COUNT_W-1:0] total;
    logic               eor;
  } annexb_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       has_st;
    status_t    st;
  } stim_row_t;

  localparam int N_DIR = 23;
  // too short; no parameter sets; zero-length SPS, one PPS, trailing byte
  stim_row_t dir_tab [N_DIR] = '{
    '{8'h01, 1'b0, 1'b0, ST_OK}, '{8'h64, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b1, 1'b1, ST_TRUNC},
    '{8'h01, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'hFC, 1'b0, 1'b0, ST_OK}, '{8'hE0, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b1, 1'b1, ST_EMPTY},
    '{8'h01, 1'b0, 1'b0, ST_OK}, '{8'h42, 1'b0, 1'b0, ST_OK}, '{8'hC0, 1'b0, 1'b0, ST_OK},
    '{8'h1E, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hE1, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h01, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h01, 1'b0, 1'b0, ST_OK}, '{8'hAB, 1'b0, 1'b0, ST_OK},
    '{8'h55, 1'b1, 1'b1, ST_OK}
  };

  annexb_item_t annexb_q[$];
  logic [7:0]   rec_bytes[$];

  // predictor state
  phase_t             p_phase = PH_HEADER;
  logic [2:0]         p_hdr = '0;
  logic [7:0]         p_sets = '0;
  logic               p_pps = 1'b0;
  logic [7:0]         p_len_hi = '0;
  logic [15:0]        p_left = '0;
  logic [2:0]         p_lsize = 3'd1;
  logic [COUNT_W-1:0] p_count = '0;
  logic [4:0]         p_nbytes = '0;

  int errors = 0;
  int n_req = 0;
  int n_res = 0;
  int n_status = 0;
  int n_rec = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;

  function automatic void clear_predictor();
    p_phase  = PH_HEADER;
    p_hdr    = '0;
    p_sets   = '0;
    p_pps    = 1'b0;
    p_len_hi = '0;
    p_left   = '0;
    p_lsize  = 3'd1;
    p_count  = '0;
    p_nbytes = '0;
  endfunction

  function automatic void push_item(logic kind, logic [7:0] b, status_t st);
    annexb_item_t it;
    it.kind  = kind;
    it.data  = b;
    it.st    = st;
    it.lsize = p_lsize;
    it.total = p_count;
    it.eor   = 1'b0;
    annexb_q.push_back(it);
  endfunction

  function automatic void emit_annexb_byte(logic [7:0] b);
    if (p_count != COUNT_MAX) p_count = p_count + COUNT_W'(1);
    push_item(1'b0, b, ST_OK);
  endfunction

  function automatic void finish_entry();
    p_sets = p_sets - 8'd1;
    if (p_sets != 8'd0) begin
      p_phase = PH_LEN_HI;
    end else if (!p_pps) begin
      p_pps = 1'b1;
      p_phase = PH_COUNT;
    end else begin
      p_phase = PH_TRAILER;
    end
  endfunction

  function automatic void predict_annexb(logic [7:0] b, logic last);
    int n0;
    status_t st;
    annexb_item_t it;
    n0 = annexb_q.size();
    if (p_nbytes < REC_CAP) p_nbytes = p_nbytes + 5'd1;
    case (p_phase)
      PH_HEADER: begin
        if (p_hdr == HEADER_SKIP - 3'd1) p_lsize = {1'b0, b[1:0]} + 3'd1;
        p_hdr = p_hdr + 3'd1;
        if (p_hdr >= HEADER_SKIP) p_phase = PH_COUNT;
      end
      PH_COUNT: begin
        p_sets = p_pps ? b : {3'b000, b[4:0]};
        if (p_sets != 8'd0) p_phase = PH_LEN_HI;
        else if (!p_pps) p_pps = 1'b1;
        else p_phase = PH_TRAILER;
      end
      PH_LEN_HI: begin
        p_len_hi = b;
        p_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        p_left = {p_len_hi, b};
        emit_annexb_byte(8'h00);
        emit_annexb_byte(8'h00);
        emit_annexb_byte(8'h00);
        emit_annexb_byte(8'h01);
        if (p_left != 16'd0) p_phase = PH_PAYLOAD;
        else finish_entry();
      end
      PH_PAYLOAD: begin
        emit_annexb_byte(b);
        p_left = p_left - 16'd1;
        if (p_left == 16'd0) finish_entry();
      end
      default: ;
    endcase
    if (last) begin
      if (p_nbytes < 5'(MIN_REC) || p_phase != PH_TRAILER) st = ST_TRUNC;
      else if (p_count == '0) st = ST_EMPTY;
      else st = ST_OK;
      push_item(1'b1, 8'h00, st);
      clear_predictor();
    end
    if (annexb_q.size() > n0) begin
      it = annexb_q.pop_back();
      it.eor = 1'b1;
      annexb_q.push_back(it);
    end
  endfunction

  task automatic send_req(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_annexb(b, last);
    n_req++;
  endtask

  // long entries only go into records that are cut short
  function automatic void add_entries(int cnt, bit allow_long);
    int len;
    for (int i = 0; i < cnt; i++) begin
      len = (allow_long && $urandom_range(3) == 0) ? 256 + $urandom_range(7)
                                                    : $urandom_range(6);
      rec_bytes.push_back(len[15:8]);
      rec_bytes.push_back(len[7:0]);
      for (int j = 0; j < len; j++) rec_bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic void build_record();
    int kind;
    int n_sps;
    int n_pps;
    int cut;
    bit cut_short;
    logic [2:0] junk;
    rec_bytes.delete();
    kind = $urandom_range(99);
    cut_short = (kind < 30);
    if (kind < 15) begin
      cut = $urandom_range(1, 12);
      for (int i = 0; i < cut; i++) rec_bytes.push_back(8'($urandom_range(255)));
    end else begin
      for (int i = 0; i < 5; i++) rec_bytes.push_back(8'($urandom_range(255)));
      n_sps = $urandom_range(3);
      junk = 3'($urandom_range(7));
      rec_bytes.push_back({junk, n_sps[4:0]});
      add_entries(n_sps, cut_short);
      n_pps = $urandom_range(3);
      rec_bytes.push_back(n_pps[7:0]);
      add_entries(n_pps, cut_short);
      cut = $urandom_range(3);
      for (int i = 0; i < cut; i++) rec_bytes.push_back(8'($urandom_range(255)));
      if (cut_short) begin
        cut = $urandom_range(1, (rec_bytes.size() > 40) ? 40 : rec_bytes.size() - 1);
        while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
      end
    end
  endfunction

  function automatic void check_annexb_out();
    annexb_item_t e;
    if (annexb_q.size() == 0) begin
      $error("unexpected result: tuser=%0d tdata=%h", out_tuser, out_tdata);
      errors++;
      return;
    end
    e = annexb_q.pop_front();
    n_res++;
    if (out_tuser) n_status++;
    if (out_tuser !== e.kind) begin
      $error("item_kind: expected %0d, got %0d", e.kind, out_tuser); errors++;
    end
    if (out_tdata[7:0] !== e.data) begin
      $error("out_byte: expected %h, got %h", e.data, out_tdata[7:0]); errors++;
    end
    if (out_tdata[9:8] !== e.st) begin
      $error("status: expected %0d, got %0d", e.st, out_tdata[9:8]); errors++;
    end
    if (out_tdata[12:10] !== e.lsize) begin
      $error("length_size: expected %0d, got %0d", e.lsize, out_tdata[12:10]); errors++;
    end
    if (out_tdata[37:13] !== e.total) begin
      $error("total_bytes: expected %0d, got %0d", e.total, out_tdata[37:13]); errors++;
    end
    if (out_tlast !== e.eor) begin
      $error("end_of_run: expected %0d, got %0d", e.eor, out_tlast); errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_annexb_out();
    if (hold_done < hold_reqs) begin
      hold_done = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #3_000_000;
    $display("tb_avcc_to_annexb_converter_core NOT OK");
    $finish;
  end

  initial begin
    annexb_item_t it;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      send_req(dir_tab[i].data, dir_tab[i].last);
      if (dir_tab[i].has_st) begin
        // typed status replaces the predicted one
        it = annexb_q.pop_back();
        it.st = dir_tab[i].st;
        annexb_q.push_back(it);
        n_rec++;
      end
    end

    for (int r = 0; n_req < N_DIR + 160 || r < 8; r++) begin
      case ((r / 2) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      if (r == 4) begin
        send_idle_pct = 0;
        hold_reqs++;
      end
      build_record();
      foreach (rec_bytes[k]) send_req(rec_bytes[k], k == rec_bytes.size() - 1);
      n_rec++;
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    recv_stall_pct = 0;

    while (annexb_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d avcC records (valid, truncated, noise, long entries).",
             n_req, n_rec);
    $display("Checked %0d results, %0d of them status items, under varied backpressure.",
             n_res, n_status);
    if (errors == 0 && annexb_q.size() == 0) begin
      $display("tb_avcc_to_annexb_converter_core OK");
    end else begin
      $display("tb_avcc_to_annexb_converter_core NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/avcc_pkg.sv
hw/rtl/avcc_parse.sv
hw/rtl/avcc_emit.sv
hw/rtl/avcc_to_annexb_converter_core.sv
hw/rtl/avcc_chk.sv
bench/tb_avcc_to_annexb_converter_core.sv
